[src/lgci_pkg.sv]
// Package for the line gradient color interpolator.
// Holds the widths, the cell word type and nothing else; no dependencies.
package lgci_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int ABS_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int DIST_W = 2 * COORD_BITS + 2;
    localparam int REM_W  = DIST_W + 2 * FRAC_BITS;
    localparam int ACC_W  = DIST_W + FRAC_BITS;
    localparam int POS_W  = FRAC_BITS + 1;
    localparam int IDX_W  = $clog2(FRAC_BITS);

    typedef struct packed {
        logic              valid;
        logic              sat;
        logic [DIST_W-1:0] full;
        logic [REM_W-1:0]  rem;
        logic [ACC_W-1:0]  acc;
        logic [FRAC_BITS-1:0] q;
        logic [31:0]       color_a;
        logic [31:0]       color_b;
    } lgci_cell_t;

endpackage

[src/lgci_front.sv]
// Distance front end: absolute differences, squares and sums over three stages.
// Depends on lgci_pkg; feeds the first position cell.
module lgci_front
    import lgci_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic [31:0]                  start_color,
    input  logic [31:0]                  end_color,
    output lgci_cell_t                   cell_out
);

    logic             v1_reg, v2_reg;
    logic [ABS_W-1:0] fx_reg, fy_reg, px_reg, py_reg;
    logic [SQ_W-1:0]  fxx_reg, fyy_reg, pxx_reg, pyy_reg;
    logic [31:0]      ca1_reg, cb1_reg, ca2_reg, cb2_reg;
    lgci_cell_t       cell_reg, cell_next;

    function automatic logic [ABS_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                  input logic signed [COORD_BITS-1:0] b);
        logic signed [ABS_W-1:0] d;
        d = {{1{b[COORD_BITS-1]}}, b} - {{1{a[COORD_BITS-1]}}, a};
        return d[ABS_W-1] ? ABS_W'(-d) : ABS_W'(d);
    endfunction

    always_comb begin
        logic [DIST_W-1:0] full, part;
        full = DIST_W'(fxx_reg) + DIST_W'(fyy_reg);
        part = DIST_W'(pxx_reg) + DIST_W'(pyy_reg);
        cell_next         = '0;
        cell_next.valid   = v2_reg;
        cell_next.sat     = (full == '0) || (part >= full);
        cell_next.full    = full;
        cell_next.rem     = REM_W'(part) << (2 * FRAC_BITS);
        cell_next.color_a = ca2_reg;
        cell_next.color_b = cb2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            cell_reg <= cell_next;
        end
        if (en) begin
            fx_reg  <= abs_diff(start_x, end_x);
            fy_reg  <= abs_diff(start_y, end_y);
            px_reg  <= abs_diff(start_x, cur_x);
            py_reg  <= abs_diff(start_y, cur_y);
            ca1_reg <= start_color;
            cb1_reg <= end_color;
            fxx_reg <= SQ_W'(fx_reg * fx_reg);
            fyy_reg <= SQ_W'(fy_reg * fy_reg);
            pxx_reg <= SQ_W'(px_reg * px_reg);
            pyy_reg <= SQ_W'(py_reg * py_reg);
            ca2_reg <= ca1_reg;
            cb2_reg <= cb1_reg;
        end
    end

    assign cell_out = cell_reg;

endmodule

[src/lgci_cell.sv]
// One position cell: decides one bit of the distance ratio square root.
// Depends on lgci_pkg; chained by the top level, one cell per fraction bit.
module lgci_cell
    import lgci_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [IDX_W-1:0] bit_idx,
    input  lgci_cell_t       cell_in,
    output lgci_cell_t       cell_out
);

    lgci_cell_t cell_reg, cell_next;

    always_comb begin
        logic [REM_W-1:0] trial;
        trial = ((REM_W'(cell_in.acc) << bit_idx) << 1)
              + (REM_W'(cell_in.full) << (2 * bit_idx));
        cell_next = cell_in;
        if (!cell_in.sat && cell_in.rem >= trial) begin
            cell_next.rem        = cell_in.rem - trial;
            cell_next.acc        = cell_in.acc + (ACC_W'(cell_in.full) << bit_idx);
            cell_next.q[bit_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

[src/lgci_blend.sv]
// Colour blend: four byte lanes weighted by the position, rounded half up.
// Depends on lgci_pkg; holds the output register of the block.
module lgci_blend
    import lgci_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  lgci_cell_t cell_in,
    output logic       out_valid,
    output logic [31:0] pixel_color
);

    localparam int PROD_W = 8 + POS_W;

    logic              v1_reg, out_valid_reg;
    logic [PROD_W-1:0] pa_reg [4];
    logic [PROD_W-1:0] pb_reg [4];
    logic [31:0]       color_reg, color_next;
    logic [POS_W-1:0]  pos;

    assign pos = cell_in.sat ? POS_W'(1) << FRAC_BITS : POS_W'(cell_in.q);

    always_comb begin
        logic [PROD_W:0] v;
        color_next = '0;
        for (int i = 0; i < 4; i++) begin
            v = (PROD_W + 1)'(pa_reg[i]) + (PROD_W + 1)'(pb_reg[i])
              + ((PROD_W + 1)'(1) << (FRAC_BITS - 1));
            color_next[8*i +: 8] = v[FRAC_BITS +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= cell_in.valid;
            out_valid_reg <= v1_reg;
        end
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                pa_reg[i] <= PROD_W'(cell_in.color_a[8*i +: 8])
                           * PROD_W'((POS_W'(1) << FRAC_BITS) - pos);
                pb_reg[i] <= PROD_W'(cell_in.color_b[8*i +: 8]) * PROD_W'(pos);
            end
            color_reg <= color_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;

endmodule

[src/line_gradient_color_interpolator.sv]
// Line gradient colour interpolator, top level: front end, cell chain, blend.
// One word is taken every cycle when the output flows.
// The chain holds one position cell per fraction bit; the whole pipeline stalls together
// while an output word waits. Reset clears the valid bits only; no state is kept.
// Depends on lgci_pkg, lgci_front, lgci_cell and lgci_blend.
module line_gradient_color_interpolator
    import lgci_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    input  logic signed [COORD_BITS-1:0] s_cur_x,
    input  logic signed [COORD_BITS-1:0] s_cur_y,
    input  logic [31:0]                  s_start_color,
    input  logic [31:0]                  s_end_color,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [31:0]                  m_pixel_color
);

    logic       en;
    lgci_cell_t chain [FRAC_BITS+1];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    lgci_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .start_x     (s_start_x),
        .start_y     (s_start_y),
        .end_x       (s_end_x),
        .end_y       (s_end_y),
        .cur_x       (s_cur_x),
        .cur_y       (s_cur_y),
        .start_color (s_start_color),
        .end_color   (s_end_color),
        .cell_out    (chain[0])
    );

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
        lgci_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .bit_idx  (IDX_W'(FRAC_BITS - 1 - i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    lgci_blend u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .cell_in     (chain[FRAC_BITS]),
        .out_valid   (m_valid),
        .pixel_color (m_pixel_color)
    );

endmodule

[tb/line_gradient_color_interpolator_tb.sv]
// Testbench for the line gradient colour interpolator: random and directed line words,
// colour blend predicted in the bench and compared with every output word.
// Depends on lgci_pkg and line_gradient_color_interpolator.
module line_gradient_color_interpolator_tb;
    import lgci_pkg::*;

    localparam int LATENCY = FRAC_BITS + 5;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [COORD_BITS-1:0] s_start_x, s_start_y, s_end_x, s_end_y, s_cur_x, s_cur_y;
    logic [31:0] s_start_color, s_end_color;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_pixel_color;

    logic [31:0] colour_queue[$];
    int error_count;
    int stall_cycles;
    int idle_cycles;
    bit hold_off;

    line_gradient_color_interpolator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_end_x(s_end_x), .s_end_y(s_end_y),
        .s_cur_x(s_cur_x), .s_cur_y(s_cur_y),
        .s_start_color(s_start_color), .s_end_color(s_end_color),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_color(m_pixel_color)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [2*COORD_BITS+1:0] dist_squared(
        logic signed [COORD_BITS-1:0] x0, logic signed [COORD_BITS-1:0] y0,
        logic signed [COORD_BITS-1:0] x1, logic signed [COORD_BITS-1:0] y1);
        logic signed [COORD_BITS+1:0] dx, dy;
        logic [2*COORD_BITS+1:0] sq;
        dx = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
        dy = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = dx * dx + dy * dy;
        return sq;
    endfunction

    function automatic logic [FRAC_BITS:0] line_position(logic [2*COORD_BITS+1:0] part,
                                                         logic [2*COORD_BITS+1:0] full);
        logic [127:0] lhs, rhs;
        logic [FRAC_BITS-1:0] q, t;
        if (full == 0 || part >= full) return (FRAC_BITS + 1)'(1) << FRAC_BITS;
        q = '0;
        rhs = 128'(part) << (2 * FRAC_BITS);
        for (int b = FRAC_BITS - 1; b >= 0; b--) begin
            t = q | (FRAC_BITS'(1) << b);
            lhs = 128'(t) * 128'(t) * 128'(full);
            if (lhs <= rhs) q = t;
        end
        return {1'b0, q};
    endfunction

    function automatic logic [31:0] blended_colour(logic [31:0] a, logic [31:0] b,
                                                   logic [FRAC_BITS:0] p);
        logic [63:0] v;
        logic [31:0] res;
        logic [63:0] one;
        one = 64'(1) << FRAC_BITS;
        res = '0;
        for (int lane = 0; lane < 4; lane++) begin
            v = 64'(a[8*lane +: 8]) * (one - 64'(p)) + 64'(b[8*lane +: 8]) * 64'(p)
                + (one >> 1);
            res[8*lane +: 8] = v[FRAC_BITS +: 8];
        end
        return res;
    endfunction

    task automatic report_mismatch(logic [31:0] got, logic [31:0] want);
        $display("mismatch: pixel_color got %h expected %h", got, want);
        error_count++;
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30));
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_line(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                             logic [15:0] ey, logic [15:0] cx, logic [15:0] cy,
                             logic [31:0] ca, logic [31:0] cb, bit gaps);
        if (gaps) random_gap();
        s_valid <= 1'b1;
        s_start_x <= sx; s_start_y <= sy; s_end_x <= ex; s_end_y <= ey;
        s_cur_x <= cx; s_cur_y <= cy; s_start_color <= ca; s_end_color <= cb;
        colour_queue.push_back(blended_colour(ca, cb,
            line_position(dist_squared(sx, sy, cx, cy), dist_squared(sx, sy, ex, ey))));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (colour_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  32'h0000_0000, 32'hffff_ffff, 0);
        send_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000,
                  32'hffff_ffff, 32'h0000_0000, 0);
        send_line(16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h1234, 16'h0000,
                  32'h1234_5678, 32'h9abc_def0, 0);
        send_line(16'h0000, 16'h0000, 16'h000a, 16'h0000, 16'h0014, 16'h0000,
                  32'h0102_0304, 32'hf0e0_d0c0, 0);
        send_line(16'h0000, 16'h0000, 16'h000a, 16'h0000, 16'h0005, 16'h0000,
                  32'h0000_0000, 32'h0101_0101, 0);
        send_line(16'h0000, 16'h0000, 16'h0003, 16'h0004, 16'h0000, 16'h0000,
                  32'haaaa_aaaa, 32'h5555_5555, 0);
        send_line(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0001, 16'hffff,
                  32'h00ff_00ff, 32'hff00_ff00, 0);
        send_line(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001,
                  32'h8080_8080, 32'h7f7f_7f7f, 0);
        send_line(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0000, 16'h0000,
                  32'h00ff_00ff, 32'h0000_ffff, 0);
        wait_drained();
    endtask

    task automatic send_random_line(bit gaps);
        logic [15:0] sx, sy, ex, ey, cx, cy;
        int span;
        sx = $urandom; sy = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            ex = $urandom; ey = $urandom; cx = $urandom; cy = $urandom;
        end else begin
            span = 1 << $urandom_range(1, 12);
            ex = sx + 16'($urandom_range(0, 2 * span) - span);
            ey = sy + 16'($urandom_range(0, 2 * span) - span);
            cx = sx + 16'((int'($signed(ex - sx)) * int'($urandom_range(0, 110))) / 100);
            cy = sy + 16'((int'($signed(ey - sy)) * int'($urandom_range(0, 110))) / 100);
        end
        send_line(sx, sy, ex, ey, cx, cy, $urandom, $urandom, gaps);
    endtask

    task automatic test_random();
        repeat (1100) send_random_line(1);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (60) send_random_line(0);
            end
            begin
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
        wait_drained();
        repeat (80) send_random_line(0);
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_start_x = '0; s_start_y = '0; s_end_x = '0; s_end_y = '0;
        s_cur_x = '0; s_cur_y = '0; s_start_color = '0; s_end_color = '0;
        error_count = 0;
        hold_off = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_back_pressure();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver: random stalls, long ones now and then, and a forced hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cycles <= 0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 2) begin
            stall_cycles <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 40);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (colour_queue.size() == 0) begin
                $display("unexpected word: pixel_color %h", m_pixel_color);
                error_count++;
            end else if (m_pixel_color !== colour_queue[0]) begin
                report_mismatch(m_pixel_color, colour_queue.pop_front());
            end else begin
                void'(colour_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end
endmodule

[line_gradient_color_interpolator.f]
src/lgci_pkg.sv
src/lgci_front.sv
src/lgci_cell.sv
src/lgci_blend.sv
src/line_gradient_color_interpolator.sv
tb/line_gradient_color_interpolator_tb.sv
